### sv/hfq_pkg.sv
// ----------------------------------------------------------------------------
// hfq_pkg
// Shared constants, types and stage structs of the terrain height query core.
// ----------------------------------------------------------------------------
`default_nettype none

package hfq_pkg;

    // grid geometry: the 7-bit cell index fields fix the grid at 128 x 128
    localparam int GRID_SIZE  = 128;
    localparam int IDX_W      = $clog2(GRID_SIZE);
    localparam int FRAC_W     = IDX_W;
    localparam int COORD_W    = 16;
    localparam int HEIGHT_W   = 16;

    // arithmetic widths
    localparam int TX_W       = COORD_W + 1;
    localparam int T_W        = TX_W + FRAC_W;
    localparam int WEIGHT_W   = FRAC_W + 1;
    localparam int PROD_W     = HEIGHT_W + WEIGHT_W + 1;
    localparam int SUM_W      = PROD_W + 2;

    // four parity banks, each one quarter of the grid
    localparam int NUM_BANKS  = 4;
    localparam int BANK_AW    = 2 * (IDX_W - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // stage enables from the pipeline control
    typedef struct packed
    {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } stage_en_t;

    // stage 1: located cell and fractions, or a write
    typedef struct packed
    {
        logic                valid;
        op_t                 op;
        logic [IDX_W-1:0]    wr_row;
        logic [IDX_W-1:0]    wr_col;
        logic [HEIGHT_W-1:0] wr_height;
        logic [IDX_W-1:0]    gx;
        logic [IDX_W-1:0]    gz;
        logic [FRAC_W-1:0]   a;
        logic [FRAC_W-1:0]   b;
        logic                oor;
    } loc_t;

    // stage 2: triangle weights alongside the bank reads
    typedef struct packed
    {
        logic                valid;
        logic                upper;
        logic                gx_odd;
        logic                gz_odd;
        logic                oor;
        logic [WEIGHT_W-1:0] w_a;
        logic [WEIGHT_W-1:0] w_b;
        logic [WEIGHT_W-1:0] w_c;
    } wgt_t;

endpackage

`default_nettype wire

### sv/hfq_ram.sv
// ----------------------------------------------------------------------------
// hfq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hfq_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/hfq_locate.sv
// ----------------------------------------------------------------------------
// hfq_locate
// Stage 1: centres and scales the query position into a cell and fractions.
// ----------------------------------------------------------------------------
`default_nettype none

module hfq_locate
    import hfq_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       item_valid,
    input  wire logic                       operation,
    input  wire logic [IDX_W-1:0]           cell_row,
    input  wire logic [IDX_W-1:0]           cell_col,
    input  wire logic signed [HEIGHT_W-1:0] cell_height,
    input  wire logic signed [COORD_W-1:0]  query_x,
    input  wire logic signed [COORD_W-1:0]  query_z,
    output loc_t                            loc_reg
);

    localparam logic signed [TX_W-1:0] HALF   = TX_W'(GRID_SIZE / 2);
    localparam logic signed [TX_W-1:0] GX_TOP = TX_W'(GRID_SIZE - 2);

    logic signed [TX_W-1:0] tx, tz;
    logic signed [T_W-1:0]  t_x, t_z;
    logic signed [TX_W-1:0] gx_full, gz_full;
    loc_t                   loc_next;

    // t = (pos + N/2) * (N-1), floor by N is the top bits, remainder the low
    always_comb
    begin
        tx      = TX_W'(query_x) + HALF;
        tz      = TX_W'(query_z) + HALF;
        t_x     = {tx, {FRAC_W{1'b0}}} - T_W'(tx);
        t_z     = {tz, {FRAC_W{1'b0}}} - T_W'(tz);
        gx_full = t_x[T_W-1:FRAC_W];
        gz_full = t_z[T_W-1:FRAC_W];

        loc_next.valid     = item_valid;
        loc_next.op        = op_t'(operation);
        loc_next.wr_row    = cell_row;
        loc_next.wr_col    = cell_col;
        loc_next.wr_height = cell_height;
        loc_next.gx        = gx_full[IDX_W-1:0];
        loc_next.gz        = gz_full[IDX_W-1:0];
        loc_next.a         = t_x[FRAC_W-1:0];
        loc_next.b         = t_z[FRAC_W-1:0];
        loc_next.oor       = gx_full[TX_W-1] || gz_full[TX_W-1]
                             || (gx_full > GX_TOP) || (gz_full > GX_TOP);
    end

    // stage register, only the valid bit is reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loc_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            loc_reg <= loc_next;
        end
    end

endmodule

`default_nettype wire

### sv/hfq_bank_read.sv
// ----------------------------------------------------------------------------
// hfq_bank_read
// Stage 2: four parity banks of the height grid. Writes land here, queries
// read all four cell corners at once, and the triangle weights are formed.
// ----------------------------------------------------------------------------
`default_nettype none

module hfq_bank_read
    import hfq_pkg::*;
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  loc_t                                     loc,
    output wgt_t                                     wgt_reg,
    output logic [NUM_BANKS-1:0][HEIGHT_W-1:0]       rd_data
);

    localparam logic [WEIGHT_W-1:0] FULL = WEIGHT_W'(GRID_SIZE);

    logic [1:0]          wbank;
    logic [BANK_AW-1:0]  waddr;
    logic [WEIGHT_W-1:0] ab;
    wgt_t                wgt_next;

    // write target: bank by index parity, address by halved indices
    // (7-bit indices always fall inside the grid)
    assign wbank = {loc.wr_row[0], loc.wr_col[0]};
    assign waddr = {loc.wr_row[IDX_W-1:1], loc.wr_col[IDX_W-1:1]};

    // one bank per corner parity
    for (genvar k = 0; k < NUM_BANKS; k++)
    begin : g_bank
        localparam logic [1:0] BK = 2'(k);

        logic [IDX_W-1:0]   row, col;
        logic [BANK_AW-1:0] raddr;
        logic               we;

        assign row   = (loc.gx[0] == BK[1]) ? loc.gx : loc.gx + IDX_W'(1);
        assign col   = (loc.gz[0] == BK[0]) ? loc.gz : loc.gz + IDX_W'(1);
        assign raddr = {row[IDX_W-1:1], col[IDX_W-1:1]};
        assign we    = en && loc.valid && (loc.op == OP_WRITE) && (wbank == BK);

        hfq_ram
        #(
            .WIDTH (HEIGHT_W),
            .DEPTH (BANK_DEPTH)
        )
        u_ram
        (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (loc.wr_height),
            .re    (en),
            .raddr (raddr),
            .rdata (rd_data[k])
        );
    end

    // triangle choice and barycentric weights in units of 1/N
    always_comb
    begin
        ab              = {1'b0, loc.a} + {1'b0, loc.b};
        wgt_next.valid  = loc.valid && (loc.op == OP_QUERY);
        wgt_next.upper  = ab > FULL;
        wgt_next.gx_odd = loc.gx[0];
        wgt_next.gz_odd = loc.gz[0];
        wgt_next.oor    = loc.oor;
        if (wgt_next.upper)
        begin
            wgt_next.w_a = FULL - {1'b0, loc.b};
            wgt_next.w_b = FULL - {1'b0, loc.a};
            wgt_next.w_c = ab - FULL;
        end
        else
        begin
            wgt_next.w_a = {1'b0, loc.a};
            wgt_next.w_b = {1'b0, loc.b};
            wgt_next.w_c = FULL - ab;
        end
    end

    // stage register, writes end here, only the valid bit is reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wgt_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            wgt_reg <= wgt_next;
        end
    end

    // a write transfer never turns into a result
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        en && loc.valid && (loc.op == OP_WRITE) |=> !wgt_reg.valid)
        else $error("write item reached the blend stage");

endmodule

`default_nettype wire

### sv/hfq_blend.sv
// ----------------------------------------------------------------------------
// hfq_blend
// Stages 3 and 4: corner selection and weight products, then the sum, the
// floor division by N and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hfq_blend
    import hfq_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  stage_en_t                          en,
    input  wgt_t                               wgt,
    input  wire logic [NUM_BANKS-1:0][HEIGHT_W-1:0] rd_data,
    output logic                               prod_valid_reg,
    output logic                               result_valid,
    output logic signed [HEIGHT_W-1:0]         terrain_height,
    output logic                               out_of_range
);

    logic signed [HEIGHT_W-1:0] h_a, h_b, h_c;
    logic signed [PROD_W-1:0]   p_a_next, p_b_next, p_c_next;
    logic signed [PROD_W-1:0]   p_a_reg, p_b_reg, p_c_reg;
    logic                       oor_reg;
    logic signed [SUM_W-1:0]    sum;
    logic signed [HEIGHT_W-1:0] height_next;

    // bank holding a corner of the given parity
    function automatic logic [HEIGHT_W-1:0] pick(
        input logic [NUM_BANKS-1:0][HEIGHT_W-1:0] data,
        input logic [1:0]                         bank
    );
        logic [HEIGHT_W-1:0] v;
        case (bank)
            2'b00:   v = data[0];
            2'b01:   v = data[1];
            2'b10:   v = data[2];
            default: v = data[3];
        endcase
        return v;
    endfunction

    // corner selection: A is (gx+1,gz), B is (gx,gz+1), C the third corner
    always_comb
    begin
        h_a = pick(rd_data, {~wgt.gx_odd, wgt.gz_odd});
        h_b = pick(rd_data, {wgt.gx_odd, ~wgt.gz_odd});
        h_c = wgt.upper ? pick(rd_data, {~wgt.gx_odd, ~wgt.gz_odd})
                        : pick(rd_data, {wgt.gx_odd, wgt.gz_odd});
        p_a_next = h_a * $signed({1'b0, wgt.w_a});
        p_b_next = h_b * $signed({1'b0, wgt.w_b});
        p_c_next = h_c * $signed({1'b0, wgt.w_c});
    end

    // blend and floor shift, zero outside the grid
    always_comb
    begin
        sum         = SUM_W'(p_a_reg) + SUM_W'(p_b_reg) + SUM_W'(p_c_reg);
        height_next = oor_reg ? '0 : sum[FRAC_W +: HEIGHT_W];
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            result_valid   <= 1'b0;
        end
        else
        begin
            if (en.en3)
            begin
                prod_valid_reg <= wgt.valid;
            end
            if (en.en4)
            begin
                result_valid <= prod_valid_reg;
            end
        end
    end

    // products and result payload
    always_ff @(posedge clk)
    begin
        if (en.en3)
        begin
            p_a_reg <= p_a_next;
            p_b_reg <= p_b_next;
            p_c_reg <= p_c_next;
            oor_reg <= wgt.oor;
        end
        if (en.en4)
        begin
            terrain_height <= height_next;
            out_of_range   <= oor_reg;
        end
    end

endmodule

`default_nettype wire

### sv/heightfield_triangle_height_query_core.sv
// ----------------------------------------------------------------------------
// heightfield_triangle_height_query_core
// Terrain height grid with triangle-interpolated queries, four-stage pipeline.
//
//   channel   handshake              payload
//   item      item_valid/item_stall  operation, cell_row, cell_col,
//                                    cell_height, query_x, query_z
//   result    result_valid/          terrain_height, out_of_range
//             result_stall
//
// One item per cycle while the result is not stalled. A write gives no result;
// a query result passes the locate, weight, product and result registers.
// Throughput is set by the four parity banks, one read port each, which
// fetch all corners of a cell in the same cycle.
// Reset clears the stage valid bits only; grid contents are undefined until
// written.
// A stall holds only the stages that are full, so bubbles close up; the item
// side stalls only when all four stages are full and the result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module heightfield_triangle_height_query_core
    import hfq_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    output logic                            item_stall,
    input  wire logic                       operation,
    input  wire logic [IDX_W-1:0]           cell_row,
    input  wire logic [IDX_W-1:0]           cell_col,
    input  wire logic signed [HEIGHT_W-1:0] cell_height,
    input  wire logic signed [COORD_W-1:0]  query_x,
    input  wire logic signed [COORD_W-1:0]  query_z,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic signed [HEIGHT_W-1:0]      terrain_height,
    output logic                            out_of_range
);

    stage_en_t                           en;
    loc_t                                loc;
    wgt_t                                wgt;
    logic [NUM_BANKS-1:0][HEIGHT_W-1:0]  rd_data;
    logic                                prod_valid;

    // a stage moves when it is empty or the next one moves
    always_comb
    begin
        en.en4 = !result_valid || !result_stall;
        en.en3 = !prod_valid || en.en4;
        en.en2 = !wgt.valid || en.en3;
        en.en1 = !loc.valid || en.en2;
    end

    assign item_stall = !en.en1;

    hfq_locate u_locate
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en.en1),
        .item_valid  (item_valid),
        .operation   (operation),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .cell_height (cell_height),
        .query_x     (query_x),
        .query_z     (query_z),
        .loc_reg     (loc)
    );

    hfq_bank_read u_bank_read
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en.en2),
        .loc     (loc),
        .wgt_reg (wgt),
        .rd_data (rd_data)
    );

    hfq_blend u_blend
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .wgt            (wgt),
        .rd_data        (rd_data),
        .prod_valid_reg (prod_valid),
        .result_valid   (result_valid),
        .terrain_height (terrain_height),
        .out_of_range   (out_of_range)
    );

    // the item side stalls only when every stage is full
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> loc.valid && wgt.valid && prod_valid && result_valid)
        else $error("item stalled with a bubble in the pipeline");

    // an out-of-grid result carries zero height
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_of_range |-> terrain_height == '0)
        else $error("out-of-grid result with non-zero height");

    // a held product stage keeps its item
    a_prod_held: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid && !en.en3 |=> prod_valid)
        else $error("product stage lost an item while held");

endmodule

`default_nettype wire

### test/heightfield_triangle_height_query_core_test.sv
// ----------------------------------------------------------------------------
// heightfield_triangle_height_query_core_test
// Self-checking bench for the terrain height query core. Grid writes and
// queries are driven with random gaps on both channels. A predictor that
// keeps its own copy of the grid works out each query result, and each
// result transfer is checked field by field, in order. Queries only touch
// grid points that have already been written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heightfield_triangle_height_query_core_test
    import hfq_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 40;
    localparam int HALF_GRID      = GRID_SIZE / 2;

    // one expected query result
    typedef struct packed
    {
        logic signed [HEIGHT_W-1:0] height;
        logic                       oor;
    } height_result_t;

    // triangle picked by a query: three corners and their weights out of GRID_SIZE
    typedef struct packed
    {
        logic                      oor;
        logic [2:0][IDX_W-1:0]     row;
        logic [2:0][IDX_W-1:0]     col;
        logic [2:0][WEIGHT_W-1:0]  weight;
    } facet_t;

    logic                       clk            = 1'b0;
    logic                       rst_n          = 1'b0;
    logic                       item_valid     = 1'b0;
    logic                       item_stall;
    logic                       operation      = OP_WRITE;
    logic [IDX_W-1:0]           cell_row       = '0;
    logic [IDX_W-1:0]           cell_col       = '0;
    logic signed [HEIGHT_W-1:0] cell_height    = '0;
    logic signed [COORD_W-1:0]  query_x        = '0;
    logic signed [COORD_W-1:0]  query_z        = '0;
    logic                       result_valid;
    logic                       result_stall   = 1'b0;
    logic signed [HEIGHT_W-1:0] terrain_height;
    logic                       out_of_range;

    // predictor copy of the grid, and which points hold a written value
    logic signed [HEIGHT_W-1:0] height_grid [GRID_SIZE][GRID_SIZE];
    bit                         grid_loaded [GRID_SIZE][GRID_SIZE];

    height_result_t pending_heights [$];
    height_result_t expected_height;

    int error_count  = 0;
    int items_sent   = 0;
    int idle_cycles  = 0;
    int stall_left   = 0;
    int hot_tx       = HALF_GRID;
    int hot_tz       = HALF_GRID;
    bit source_quiet = 1'b0;
    bit sink_quiet   = 1'b0;
    bit sink_heavy   = 1'b0;

    heightfield_triangle_height_query_core u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .operation      (operation),
        .cell_row       (cell_row),
        .cell_col       (cell_col),
        .cell_height    (cell_height),
        .query_x        (query_x),
        .query_z        (query_z),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .terrain_height (terrain_height),
        .out_of_range   (out_of_range)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic longint floor_div(input longint v, input longint d);
        longint q;
        q = v / d;
        if ((v % d) != 0 && v < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    // centre the position, scale by (N-1)/N, then pick the triangle of the cell
    function automatic facet_t triangle_of(input logic signed [COORD_W-1:0] qx,
                                           input logic signed [COORD_W-1:0] qz);
        facet_t facet;
        longint n;
        longint tx;
        longint tz;
        longint gx;
        longint gz;
        longint a;
        longint b;
        n  = GRID_SIZE;
        tx = longint'(qx) + n / 2;
        tz = longint'(qz) + n / 2;
        gx = floor_div(tx * (n - 1), n);
        gz = floor_div(tz * (n - 1), n);
        facet = '0;
        facet.oor = (gx < 0 || gz < 0 || gx >= n - 1 || gz >= n - 1);
        if (!facet.oor)
        begin
            a = tx * (n - 1) - gx * n;
            b = tz * (n - 1) - gz * n;
            // split on the anti-diagonal, points on it belong to the lower half
            if (a + b <= n)
            begin
                facet.row[0]    = IDX_W'(gx);
                facet.col[0]    = IDX_W'(gz);
                facet.weight[0] = WEIGHT_W'(n - a - b);
                facet.row[1]    = IDX_W'(gx + 1);
                facet.col[1]    = IDX_W'(gz);
                facet.weight[1] = WEIGHT_W'(a);
                facet.row[2]    = IDX_W'(gx);
                facet.col[2]    = IDX_W'(gz + 1);
                facet.weight[2] = WEIGHT_W'(b);
            end
            else
            begin
                facet.row[0]    = IDX_W'(gx + 1);
                facet.col[0]    = IDX_W'(gz);
                facet.weight[0] = WEIGHT_W'(n - b);
                facet.row[1]    = IDX_W'(gx + 1);
                facet.col[1]    = IDX_W'(gz + 1);
                facet.weight[1] = WEIGHT_W'(a + b - n);
                facet.row[2]    = IDX_W'(gx);
                facet.col[2]    = IDX_W'(gz + 1);
                facet.weight[2] = WEIGHT_W'(n - a);
            end
        end
        return facet;
    endfunction

    // barycentric blend of the three corners, floored and clamped to the height range
    function automatic height_result_t predict_height(input logic signed [COORD_W-1:0] qx,
                                                      input logic signed [COORD_W-1:0] qz);
        facet_t         facet;
        height_result_t res;
        longint         acc;
        longint         h;
        facet      = triangle_of(qx, qz);
        res.oor    = facet.oor;
        res.height = '0;
        if (!facet.oor)
        begin
            acc = 0;
            for (int i = 0; i < 3; i++)
            begin
                acc += longint'(facet.weight[i])
                     * longint'(height_grid[facet.row[i]][facet.col[i]]);
            end
            h = floor_div(acc, longint'(GRID_SIZE));
            if (h > 32767)
            begin
                h = 32767;
            end
            if (h < -32768)
            begin
                h = -32768;
            end
            res.height = h[HEIGHT_W-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------------

    // mostly short gaps, a few long ones
    function automatic int pick_gap(input bit quiet, input bit heavy);
        int r;
        if (quiet)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (heavy && r < 50)
        begin
            return $urandom_range(1, 8);
        end
        if (r < 60)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] random_height();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 16'sh7FFF;
        end
        if (r == 1)
        begin
            return 16'sh8000;
        end
        return HEIGHT_W'($urandom);
    endfunction

    // grid index close to a hot spot, kept on the grid
    function automatic int near_spot(input int spot);
        int v;
        v = spot + $urandom_range(0, 12) - 6;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > GRID_SIZE - 1)
        begin
            v = GRID_SIZE - 1;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // item channel
    // ------------------------------------------------------------------------

    task automatic send_item(input op_t                        op,
                             input logic [IDX_W-1:0]           row,
                             input logic [IDX_W-1:0]           col,
                             input logic signed [HEIGHT_W-1:0] height,
                             input logic signed [COORD_W-1:0]  qx,
                             input logic signed [COORD_W-1:0]  qz);
        int gap;
        gap = pick_gap(source_quiet, 1'b0);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation   <= op;
        cell_row    <= row;
        cell_col    <= col;
        cell_height <= height;
        query_x     <= qx;
        query_z     <= qz;
        item_valid  <= 1'b1;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        // transfer taken: update the grid copy or queue the expected height
        items_sent++;
        if (op == OP_WRITE)
        begin
            height_grid[row][col] = height;
            grid_loaded[row][col] = 1'b1;
        end
        else
        begin
            pending_heights.insert(pending_heights.size(), predict_height(qx, qz));
        end
    endtask

    task automatic send_write(input int row, input int col,
                              input logic signed [HEIGHT_W-1:0] height);
        send_item(OP_WRITE, IDX_W'(row), IDX_W'(col), height,
                  COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // load any corner not yet written (or all of them on refresh), then query
    task automatic issue_query(input logic signed [COORD_W-1:0] qx,
                               input logic signed [COORD_W-1:0] qz,
                               input bit                        refresh);
        facet_t facet;
        facet = triangle_of(qx, qz);
        if (!facet.oor)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (refresh || !grid_loaded[facet.row[i]][facet.col[i]])
                begin
                    send_write(int'(facet.row[i]), int'(facet.col[i]), random_height());
                end
            end
        end
        send_item(OP_QUERY, IDX_W'($urandom), IDX_W'($urandom), HEIGHT_W'($urandom),
                  qx, qz);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_heights.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // mixed traffic centred on a wandering hot spot so queries hit loaded cells
    task automatic random_traffic(input int target_items);
        int                        first;
        int                        r;
        int                        tx;
        int                        tz;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qz;
        first = items_sent;
        while (items_sent - first < target_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                // off-grid query, full-range coordinates
                qx = COORD_W'($urandom);
                qz = COORD_W'($urandom);
                if (qx >= -HALF_GRID && qx < HALF_GRID && qz >= -HALF_GRID && qz < HALF_GRID)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        qx = COORD_W'(-HALF_GRID - 1 - $urandom_range(0, 32703));
                    end
                    else
                    begin
                        qx = COORD_W'(HALF_GRID + $urandom_range(0, 32703));
                    end
                end
                issue_query(qx, qz, 1'b0);
            end
            else if (r < 28)
            begin
                if ($urandom_range(0, 1))
                begin
                    send_write(near_spot(hot_tx), near_spot(hot_tz), random_height());
                end
                else
                begin
                    send_write($urandom_range(0, GRID_SIZE - 1),
                               $urandom_range(0, GRID_SIZE - 1), random_height());
                end
            end
            else if (r < 32)
            begin
                hot_tx = $urandom_range(0, GRID_SIZE - 1);
                hot_tz = $urandom_range(0, GRID_SIZE - 1);
            end
            else
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    tx = near_spot(hot_tx);
                    tz = near_spot(hot_tz);
                end
                else
                begin
                    tx = $urandom_range(0, GRID_SIZE - 1);
                    tz = $urandom_range(0, GRID_SIZE - 1);
                end
                qx = COORD_W'(tx - HALF_GRID);
                qz = COORD_W'(tz - HALF_GRID);
                issue_query(qx, qz, $urandom_range(0, 9) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result channel
    // ------------------------------------------------------------------------

    // random stall on the result side
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            stall_left = pick_gap(sink_quiet, sink_heavy);
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // compare each result transfer with the oldest expected height
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_heights.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected result, terrain_height %0d out_of_range %b",
                             $time, terrain_height, out_of_range);
                end
            end
            else
            begin
                expected_height = pending_heights.pop_front();
                if (terrain_height !== expected_height.height)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("%0t: terrain_height expected %0d, got %0d",
                                 $time, expected_height.height, terrain_height);
                    end
                end
                if (out_of_range !== expected_height.oor)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("%0t: out_of_range expected %b, got %b",
                                 $time, expected_height.oor, out_of_range);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("heightfield_triangle_height_query_core_test: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // grid corners, extreme heights, both triangles, the diagonal, off-grid
    task automatic test_directed_corners();
        send_write(0, 0, 16'sh7FFF);
        send_write(1, 0, 16'sh8000);
        send_write(0, 1, 16'sh8000);
        send_write(1, 1, 16'sh7FFF);
        issue_query(-64, -64, 1'b0);
        issue_query(-63, -63, 1'b0);
        issue_query(-64, -63, 1'b0);
        // far corner of the grid, last whole cell
        send_write(126, 126, 16'shFFFF);
        send_write(127, 126, 16'sh7FFF);
        send_write(126, 127, 16'sh8000);
        send_write(127, 127, 16'sh5555);
        issue_query(63, 63, 1'b0);
        // point lying exactly on the anti-diagonal
        send_write(126, 0, 16'sh8000);
        send_write(127, 0, 16'sh7FFF);
        send_write(126, 1, 16'sh0001);
        issue_query(63, -63, 1'b0);
        // just outside and far outside the grid
        issue_query(16'sh8000, 16'sh8000, 1'b0);
        issue_query(16'sh7FFF, 16'sh7FFF, 1'b0);
        issue_query(-65, 0, 1'b0);
        issue_query(64, 0, 1'b0);
        issue_query(0, -65, 1'b0);
        issue_query(0, 64, 1'b0);
        wait_drained();
    endtask

    // random mix, sender pausing for the results after each chunk
    task automatic test_random_traffic();
        for (int k = 0; k < 3; k++)
        begin
            random_traffic(300);
            wait_drained();
        end
    endtask

    // no gaps anywhere: fresh corner writes straight ahead of the reads
    task automatic test_back_to_back();
        int tx;
        int tz;
        source_quiet = 1'b1;
        sink_quiet   = 1'b1;
        for (int k = 0; k < 50; k++)
        begin
            tx = $urandom_range(0, GRID_SIZE - 1);
            tz = $urandom_range(0, GRID_SIZE - 1);
            issue_query(COORD_W'(tx - HALF_GRID), COORD_W'(tz - HALF_GRID), 1'b1);
            issue_query(COORD_W'(tx - HALF_GRID), COORD_W'(tz - HALF_GRID), 1'b0);
        end
        wait_drained();
        source_quiet = 1'b0;
        sink_quiet   = 1'b0;
    endtask

    // result side stalls often; sender runs gapless, then with random gaps
    task automatic test_result_backpressure();
        source_quiet = 1'b1;
        sink_heavy   = 1'b1;
        random_traffic(150);
        source_quiet = 1'b0;
        random_traffic(100);
        wait_drained();
        sink_heavy   = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_directed_corners();
        test_random_traffic();
        test_back_to_back();
        test_result_backpressure();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_heights.size() == 0)
        begin
            $display("heightfield_triangle_height_query_core_test: done, clean");
        end
        else
        begin
            $display("heightfield_triangle_height_query_core_test: done, errors");
        end
        $finish;
    end

endmodule

### heightfield_triangle_height_query_core.f
sv/hfq_pkg.sv
sv/hfq_ram.sv
sv/hfq_locate.sv
sv/hfq_bank_read.sv
sv/hfq_blend.sv
sv/heightfield_triangle_height_query_core.sv
test/heightfield_triangle_height_query_core_test.sv
